// ----- hw/rtl/mgmt_pkg.sv -----
package mgmt_pkg;

    localparam int GROUPS  = 256;
    localparam int MEMBERS = 32;
    localparam int SW      = $clog2(GROUPS);
    localparam int MIW     = $clog2(MEMBERS);
    localparam int CW      = $clog2(MEMBERS + 1);
    localparam int TW      = $clog2(GROUPS + 1);
    localparam int AW      = SW + MIW;

    typedef enum logic [2:0] {
        ACT_REPORT, ACT_LEAVE, ACT_STATIC, ACT_DELETE,
        ACT_PURGE, ACT_LOOKUP, ACT_TICK, ACT_NONE
    } t_action;

    typedef enum logic [2:0] {
        STS_OK, STS_NOT_FOUND, STS_TABLE_FULL, STS_LIST_FULL, STS_DISABLED
    } t_status;

    localparam logic [1:0] CFG_V4_EN = 2'd0;
    localparam logic [1:0] CFG_V6_EN = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    typedef struct packed {
        logic [47:0]   mac;
        logic          stat;
        logic [31:0]   stamp;
        logic [CW-1:0] cnt;
    } t_meta;

    typedef struct packed {
        logic [8:0]  removed;
        logic [8:0]  ecount;
        logic [31:0] age;
        logic        stat;
        logic [5:0]  count;
        logic [15:0] mport;
        logic        found;
        logic [2:0]  status;
    } t_result;

    function automatic logic [47:0] ip_to_mac(input logic v6, input logic [63:0] low);
        logic [47:0] m;
        if (v6) begin
            m = {16'h3333, low[31:0]};
        end else begin
            m = {24'h01005E, 1'b0, low[22:0]};
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/mcast_group_membership_table_top.sv -----
// Multicast group membership table. A single sequencer walks the 256 group slots,
// reading one slot record per step from the slot memory and comparing it against
// the key, then walks the member list of the chosen group through the member
// memory. A report, leave, static add, delete or lookup ends its slot search at
// the matching group; a lookup listing waits on the output for each member. A tick
// walks all slots unless the age limit is zero; a purge always walks all slots and
// also walks the member list of every valid group. The next item is taken once the
// last result of the previous one sits in the output register. A lookup that finds
// its group gives one result per member, tlast on the final one; every other action
// gives one result.
module mcast_group_membership_table_top
    import mgmt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // mac key, group_ip_high, group_ip_low, port, whole_group, zero pad
    input  logic [199:0]  s_axis_tdata,
    // action, is_ipv6
    input  logic [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status, found, member_port, member_count, entry_static, entry_age,
    // entry_count, removed_count, zero pad
    output logic [79:0]   m_axis_tdata,
    output logic          m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_A, S_SCAN_B, S_SCAN_END, S_REM_A, S_REM_B, S_REM_END,
        S_ADD_A, S_ADD_B, S_ADD_END, S_LIST_A, S_LIST_B, S_EMIT
    } t_state;

    t_state         r_state, n_state;
    t_action        r_act, n_act;
    t_status        r_status, n_status;
    logic [47:0]    r_key, n_key;
    logic [15:0]    r_port, n_port;
    logic           r_whole, n_whole;
    logic [31:0]    r_now, n_now;
    logic [TW-1:0]  r_total, n_total;
    logic [TW-1:0]  r_removed, n_removed;
    logic [SW-1:0]  r_slot, n_slot;
    logic [SW-1:0]  r_free, n_free;
    logic           r_have_free, n_have_free;
    t_meta          r_meta, n_meta;
    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_shift, n_shift;
    logic [GROUPS-1:0] r_valid, n_valid;
    t_result        r_pend, n_pend;
    logic           r_plast, n_plast;
    t_result        r_res, n_res;
    logic           r_olast, n_olast;
    logic           r_ovalid, n_ovalid;
    logic           r_v4en, r_v6en;
    logic [15:0]    r_limit;

    t_meta          meta_mem [GROUPS];
    logic [15:0]    mbr_mem [GROUPS * MEMBERS];
    t_meta          r_mrd;
    logic [15:0]    r_mq;

    logic           meta_we, mbr_we;
    logic [SW-1:0]  meta_wa;
    t_meta          meta_wd;
    logic [AW-1:0]  mbr_wa;
    logic [15:0]    mbr_wd;

    logic [CW-1:0]  idx_m1;
    logic [CW-1:0]  rem_n;
    logic           slot_last;
    logic           in_acc;
    logic           en;
    t_action        in_act;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_res};
    assign m_axis_tlast  = r_olast;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_act    = t_action'(s_axis_tuser[2:0]);
    assign en        = s_axis_tuser[3] ? r_v6en : r_v4en;
    assign idx_m1    = r_idx - 1'b1;
    assign rem_n     = r_n - CW'(r_shift);
    assign slot_last = (r_slot == SW'(GROUPS - 1));

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_status    = r_status;
        n_key       = r_key;
        n_port      = r_port;
        n_whole     = r_whole;
        n_now       = r_now;
        n_total     = r_total;
        n_removed   = r_removed;
        n_slot      = r_slot;
        n_free      = r_free;
        n_have_free = r_have_free;
        n_meta      = r_meta;
        n_n         = r_n;
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_plast     = r_plast;
        n_res       = r_res;
        n_olast     = r_olast;
        n_ovalid    = r_ovalid && !m_axis_tready;
        meta_we     = 1'b0;
        meta_wa     = r_slot;
        meta_wd     = r_meta;
        mbr_we      = 1'b0;
        mbr_wa      = {r_slot, r_idx[MIW-1:0]};
        mbr_wd      = r_port;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act       = in_act;
                    n_port      = s_axis_tdata[191:176];
                    n_whole     = s_axis_tdata[192];
                    n_status    = STS_OK;
                    n_removed   = '0;
                    n_slot      = '0;
                    n_have_free = 1'b0;
                    n_pend      = '0;
                    n_plast     = 1'b1;
                    if (in_act == ACT_REPORT || in_act == ACT_LEAVE) begin
                        n_key = ip_to_mac(s_axis_tuser[3], s_axis_tdata[175:112]);
                    end else begin
                        n_key = s_axis_tdata[47:0];
                    end
                    priority if ((in_act == ACT_REPORT || in_act == ACT_LEAVE) && !en) begin
                        n_status = STS_DISABLED;
                        n_state  = S_EMIT;
                    end else if (in_act == ACT_NONE) begin
                        n_state = S_EMIT;
                    end else if (in_act == ACT_TICK) begin
                        n_now   = r_now + 32'd1;
                        n_state = (r_limit == 16'd0) ? S_EMIT : S_SCAN_A;
                    end else begin
                        n_state = S_SCAN_A;
                    end
                end
            end
            S_SCAN_A: begin
                n_state = S_SCAN_B;
            end
            S_SCAN_B: begin
                n_state = slot_last ? S_SCAN_END : S_SCAN_A;
                n_slot  = r_slot + 1'b1;
                if (r_act == ACT_TICK) begin
                    if (r_valid[r_slot] && !r_mrd.stat &&
                        (r_now - r_mrd.stamp) > {16'd0, r_limit}) begin
                        n_valid[r_slot] = 1'b0;
                        n_total         = r_total - 1'b1;
                        n_removed       = r_removed + 1'b1;
                    end
                end else if (r_act == ACT_PURGE) begin
                    if (r_valid[r_slot]) begin
                        n_slot  = r_slot;
                        n_meta  = r_mrd;
                        n_n     = r_mrd.cnt;
                        n_idx   = '0;
                        n_shift = 1'b0;
                        n_state = S_REM_A;
                    end
                end else if (r_valid[r_slot] && r_mrd.mac == r_key) begin
                    n_slot  = r_slot;
                    n_meta  = r_mrd;
                    n_n     = r_mrd.cnt;
                    n_idx   = '0;
                    n_shift = 1'b0;
                    unique case (r_act)
                        ACT_REPORT, ACT_STATIC: n_state = S_ADD_A;
                        ACT_LEAVE: n_state = S_REM_A;
                        ACT_DELETE: begin
                            if (r_whole) begin
                                n_valid[r_slot] = 1'b0;
                                n_total         = r_total - 1'b1;
                                n_removed       = r_removed + 1'b1;
                                n_state         = S_EMIT;
                            end else begin
                                n_state = S_REM_A;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (r_mrd.cnt == '0) begin
                                n_pend.found = 1'b1;
                                n_pend.count = 6'(r_mrd.cnt);
                                n_pend.stat  = r_mrd.stat;
                                n_pend.age   = r_now - r_mrd.stamp;
                                n_plast      = 1'b1;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_LIST_A;
                            end
                        end
                        default: n_state = S_EMIT;
                    endcase
                end else if (!r_valid[r_slot] && !r_have_free) begin
                    n_have_free = 1'b1;
                    n_free      = r_slot;
                end
            end
            S_SCAN_END: begin
                n_state = S_EMIT;
                if (r_act == ACT_REPORT || r_act == ACT_STATIC) begin
                    if (r_have_free) begin
                        meta_we         = 1'b1;
                        meta_wa         = r_free;
                        meta_wd.mac     = r_key;
                        meta_wd.stat    = (r_act == ACT_STATIC);
                        meta_wd.stamp   = r_now;
                        meta_wd.cnt     = CW'(1);
                        mbr_we          = 1'b1;
                        mbr_wa          = {r_free, {MIW{1'b0}}};
                        n_valid[r_free] = 1'b1;
                        n_total         = r_total + 1'b1;
                    end else begin
                        n_status = STS_TABLE_FULL;
                    end
                end else if (r_act == ACT_LEAVE || r_act == ACT_DELETE ||
                             r_act == ACT_LOOKUP) begin
                    n_status = STS_NOT_FOUND;
                end
            end
            S_REM_A: begin
                n_state = (r_idx == r_n) ? S_REM_END : S_REM_B;
            end
            S_REM_B: begin
                if (r_shift) begin
                    mbr_we = 1'b1;
                    mbr_wa = {r_slot, idx_m1[MIW-1:0]};
                    mbr_wd = r_mq;
                end else if (r_mq == r_port) begin
                    n_shift = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_REM_A;
            end
            S_REM_END: begin
                if (rem_n == '0) begin
                    n_valid[r_slot] = 1'b0;
                    n_total         = r_total - 1'b1;
                    n_removed       = r_removed + 1'b1;
                end else begin
                    meta_we     = r_shift;
                    meta_wd.cnt = rem_n;
                end
                if (r_act == ACT_PURGE) begin
                    n_slot  = r_slot + 1'b1;
                    n_state = slot_last ? S_SCAN_END : S_SCAN_A;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_ADD_A: begin
                n_state = (r_idx == r_n) ? S_ADD_END : S_ADD_B;
            end
            S_ADD_B: begin
                if (r_mq == r_port) begin
                    meta_we       = 1'b1;
                    meta_wd.stamp = r_now;
                    n_state       = S_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ADD_A;
                end
            end
            S_ADD_END: begin
                n_state = S_EMIT;
                if (r_n >= CW'(MEMBERS)) begin
                    n_status = STS_LIST_FULL;
                end else begin
                    mbr_we        = 1'b1;
                    mbr_wa        = {r_slot, r_n[MIW-1:0]};
                    meta_we       = 1'b1;
                    meta_wd.stamp = r_now;
                    meta_wd.cnt   = r_n + 1'b1;
                end
            end
            S_LIST_A: begin
                n_state = S_LIST_B;
            end
            S_LIST_B: begin
                n_pend.found = 1'b1;
                n_pend.mport = r_mq;
                n_pend.count = 6'(r_n);
                n_pend.stat  = r_meta.stat;
                n_pend.age   = r_now - r_meta.stamp;
                n_plast      = (r_idx + 1'b1 == r_n);
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_res         = r_pend;
                    n_res.status  = r_status;
                    n_res.ecount  = 9'(r_total);
                    n_res.removed = 9'(r_removed);
                    n_olast       = r_plast;
                    n_ovalid      = 1'b1;
                    if (r_plast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_LIST_A;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_total  <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_v4en   <= 1'b0;
            r_v6en   <= 1'b0;
            r_limit  <= 16'd260;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_total  <= n_total;
            r_valid  <= n_valid;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_V4_EN: r_v4en  <= i_cfg_data[0];
                    CFG_V6_EN: r_v6en  <= i_cfg_data[0];
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_act       <= n_act;
        r_status    <= n_status;
        r_key       <= n_key;
        r_port      <= n_port;
        r_whole     <= n_whole;
        r_removed   <= n_removed;
        r_slot      <= n_slot;
        r_free      <= n_free;
        r_have_free <= n_have_free;
        r_meta      <= n_meta;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_shift     <= n_shift;
        r_pend      <= n_pend;
        r_plast     <= n_plast;
        r_res       <= n_res;
        r_olast     <= n_olast;
    end

    // slot records and member lists
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        r_mrd <= meta_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (mbr_we) begin
            mbr_mem[mbr_wa] <= mbr_wd;
        end
        r_mq <= mbr_mem[{r_slot, r_idx[MIW-1:0]}];
    end

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(GROUPS))
        else $error("group total out of range");

    a_total_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_total))
        else $error("group total disagrees with valid slots");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");
`endif

endmodule
